// ===== src/uint_to_decimal_ascii_defines.svh =====
// Assertion macros for the decimal ASCII converter.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef UINT_TO_DECIMAL_ASCII_DEFINES_SVH
`define UINT_TO_DECIMAL_ASCII_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define U2DA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A trigger that must be followed by a consequence in the next cycle.
`define U2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/u2da_pkg.sv =====
// Shared types and constants for the decimal ASCII converter.
// Depends on nothing; used by the BCD cell, the BCD chain, the top level and the testbench.
package u2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int FIXED_W    = 5;
    localparam int CODE_W     = 6;
    localparam int TOTAL_W    = 5;
    localparam int BCD_W      = 4;
    // A 32-bit value has at most ten decimal digits.
    localparam int NUM_BCD    = 10;
    localparam int BCD_IDX_W  = $clog2(NUM_BCD);
    // Two value bits enter the chain per cycle.
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    localparam logic [CODE_W-1:0] ASCII_ZERO = CODE_W'(48);

    typedef logic [NUM_BCD-1:0][BCD_W-1:0] t_digits;

    typedef struct packed {
        logic load;
        logic shift;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } t_state;

endpackage

// ===== src/u2da_bcd_cell.sv =====
// One BCD digit cell of the shift-and-add-3 chain.
// Depends on u2da_pkg for the digit width.
module u2da_bcd_cell (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_shift,
    input  logic [1:0]                  i_carry,
    output logic [1:0]                  o_carry,
    output logic [u2da_pkg::BCD_W-1:0]  o_digit
);

    logic [u2da_pkg::BCD_W-1:0] r_digit;
    logic [u2da_pkg::BCD_W-1:0] n_digit;
    logic [u2da_pkg::BCD_W-1:0] w_adj1;
    logic [u2da_pkg::BCD_W-1:0] w_mid;
    logic [u2da_pkg::BCD_W-1:0] w_adj2;

    // Digits of five or more get three added so the shift carries into the next decade.
    function automatic logic [u2da_pkg::BCD_W-1:0] adj3(input logic [u2da_pkg::BCD_W-1:0] d);
        adj3 = (d >= u2da_pkg::BCD_W'(5)) ? d + u2da_pkg::BCD_W'(3) : d;
    endfunction

    // Two adjust-and-shift steps per cycle while i_shift is high; the upper bit of each step goes to the next cell.
    always_comb begin
        w_adj1  = adj3(r_digit);
        w_mid   = {w_adj1[2:0], i_carry[1]};
        w_adj2  = adj3(w_mid);
        n_digit = {w_adj2[2:0], i_carry[0]};
        o_carry = {w_adj1[3], w_adj2[3]};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_digit <= '0;
        end else if (i_shift) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

// ===== src/u2da_bcd_chain.sv =====
// Row of BCD cells fed from a value shift register, two bits per cycle while i_ctl.shift is high.
// Depends on u2da_pkg and u2da_bcd_cell.
module u2da_bcd_chain (
    input  logic                          i_clk,
    input  u2da_pkg::t_chain_ctl          i_ctl,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    output u2da_pkg::t_digits             o_digits,
    output logic                          o_overflow
);

    logic [u2da_pkg::VALUE_W-1:0]    r_bits;
    logic [u2da_pkg::NUM_BCD:0][1:0] w_carry;

    // The value leaves most significant bits first.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bits <= i_value;
        end else if (i_ctl.shift) begin
            r_bits <= {r_bits[u2da_pkg::VALUE_W-3:0], 2'b00};
        end
    end

    assign w_carry[0] = r_bits[u2da_pkg::VALUE_W-1 -: 2];

    // Each cell takes its carries from the cell below it.
    for (genvar k = 0; k < u2da_pkg::NUM_BCD; k++) begin : g_cell
        u2da_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (i_ctl.load),
            .i_shift (i_ctl.shift),
            .i_carry (w_carry[k]),
            .o_carry (w_carry[k+1]),
            .o_digit (o_digits[k])
        );
    end

    // Carry out of the top decade would mean a digit was lost.
    assign o_overflow = |w_carry[u2da_pkg::NUM_BCD];

endmodule

// ===== src/uint_to_decimal_ascii.sv =====
// Unsigned 32-bit to decimal ASCII converter, top level.
// Input channel: i_valid / o_ready carry i_value and i_fixed_digits (0 = minimal digits,
// otherwise that many digits, zero padded, saturated to MAX_DIGITS, high digits dropped).
// Output channel: o_valid / i_ready carry one character per transfer, most significant
// first, with o_last_char on the final one and o_char_total the count of the value.
// One value is handled at a time. After acceptance the BCD chain converts two bits per
// cycle in the conversion state, the sizing state then fixes the character count, and
// the emit state offers the characters, one per transfer. The next value is accepted
// only after the controller has returned to idle, so a new value is never taken before
// the last character of the previous one has been transferred.
// A stall on the output simply holds the current character; o_ready stays low until the
// last character has been transferred.
// Reset returns the controller to idle with o_ready high and o_valid low; nothing else
// needs clearing, since the chain is cleared when each value is loaded.
// Depends on u2da_pkg, u2da_bcd_chain and uint_to_decimal_ascii_defines.svh.
`include "uint_to_decimal_ascii_defines.svh"

module uint_to_decimal_ascii #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    input  logic [u2da_pkg::FIXED_W-1:0]  i_fixed_digits,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u2da_pkg::CODE_W-1:0]   o_char_code,
    output logic                          o_last_char,
    output logic [u2da_pkg::TOTAL_W-1:0]  o_char_total
);

    localparam int COUNT_W = $clog2(MAX_DIGITS + 1);

    u2da_pkg::t_state                  r_state;
    u2da_pkg::t_state                  n_state;
    u2da_pkg::t_chain_ctl              w_ctl;
    u2da_pkg::t_digits                 w_digits;
    logic                              w_overflow;
    logic [u2da_pkg::STEP_W-1:0]       r_step;
    logic [u2da_pkg::STEP_W-1:0]       n_step;
    logic [u2da_pkg::FIXED_W-1:0]      r_req;
    logic [COUNT_W-1:0]                r_count;
    logic [COUNT_W-1:0]                n_count;
    logic [COUNT_W-1:0]                r_pos;
    logic [COUNT_W-1:0]                n_pos;
    logic [COUNT_W-1:0]                w_msd;
    logic [COUNT_W-1:0]                w_size;
    logic [u2da_pkg::BCD_W-1:0]        w_sel;

    u2da_bcd_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_value    (i_value),
        .o_digits   (w_digits),
        .o_overflow (w_overflow)
    );

    // Minimal digit count: one above the highest nonzero digit, at least one.
    always_comb begin
        w_msd = COUNT_W'(1);
        for (int k = 0; k < u2da_pkg::NUM_BCD; k++) begin
            if (w_digits[k] != '0) begin
                w_msd = COUNT_W'(k + 1);
            end
        end
    end

    // Character count for this value; minimal mode is not clamped to MAX_DIGITS.
    always_comb begin
        if (r_req == '0) begin
            w_size = w_msd;
        end else if (32'(r_req) > MAX_DIGITS) begin
            w_size = COUNT_W'(MAX_DIGITS);
        end else begin
            w_size = COUNT_W'(r_req);
        end
    end

    // Positions above the tenth decimal digit read as zero.
    always_comb begin
        if (r_pos < COUNT_W'(u2da_pkg::NUM_BCD)) begin
            w_sel = w_digits[r_pos[u2da_pkg::BCD_IDX_W-1:0]];
        end else begin
            w_sel = '0;
        end
    end

    assign o_char_code  = u2da_pkg::ASCII_ZERO + u2da_pkg::CODE_W'(w_sel);
    assign o_last_char  = (r_pos == '0);
    assign o_char_total = u2da_pkg::TOTAL_W'(r_count);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u2da_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_count <= n_count;
        r_pos   <= n_pos;
        if (i_valid && o_ready) begin
            r_req <= i_fixed_digits;
        end
    end

    // Next state and outputs.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_count     = r_count;
        n_pos       = r_pos;
        w_ctl.load  = 1'b0;
        w_ctl.shift = 1'b0;
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        case (r_state)
            u2da_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    w_ctl.load = 1'b1;
                    n_step     = '0;
                    n_state    = u2da_pkg::ST_CONV;
                end
            end
            u2da_pkg::ST_CONV: begin
                w_ctl.shift = 1'b1;
                n_step      = r_step + u2da_pkg::STEP_W'(1);
                if (r_step == u2da_pkg::STEP_W'(u2da_pkg::CONV_STEPS - 1)) begin
                    n_state = u2da_pkg::ST_SIZE;
                end
            end
            u2da_pkg::ST_SIZE: begin
                n_count = w_size;
                n_pos   = w_size - COUNT_W'(1);
                n_state = u2da_pkg::ST_EMIT;
            end
            u2da_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (r_pos == '0) begin
                        n_state = u2da_pkg::ST_IDLE;
                    end else begin
                        n_pos = r_pos - COUNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = u2da_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks on the controller and the chain.
    `U2DA_ASSERT(a_no_overflow, !((r_state == u2da_pkg::ST_CONV) && w_overflow), "BCD chain overflow")
    `U2DA_ASSERT(a_one_side, !(o_ready && o_valid), "input accepted while a character is offered")
    `U2DA_ASSERT_NEXT(a_last_ends, o_valid && i_ready && o_last_char, !o_valid, "output after last character")
    `U2DA_ASSERT_NEXT(a_total_holds, o_valid && i_ready && !o_last_char, o_valid && $stable(o_char_total), "character total changed within a value")

endmodule

// ===== tb/tb_uint_to_decimal_ascii.sv =====
// Self-checking testbench for the unsigned 32-bit to decimal ASCII converter.
// Depends on u2da_pkg and the uint_to_decimal_ascii top level; predicts every
// character of each value and checks the output stream in order.
`timescale 1ns / 100ps

module tb_uint_to_decimal_ascii;

    localparam int MAX_DIGITS    = 16;
    localparam int RADIX         = 10;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_IDLE      = 15;
    localparam int DRAIN_CYCLES  = 48;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 210;
    localparam int BURST_ITEMS   = 40;

    // One expected output character.
    typedef struct packed {
        logic [u2da_pkg::CODE_W-1:0]  code;
        logic                         last;
        logic [u2da_pkg::TOTAL_W-1:0] total;
    } t_char;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [u2da_pkg::VALUE_W-1:0]   i_value;
    logic [u2da_pkg::FIXED_W-1:0]   i_fixed_digits;
    logic                           o_valid;
    logic                           i_ready;
    logic [u2da_pkg::CODE_W-1:0]    o_char_code;
    logic                           o_last_char;
    logic [u2da_pkg::TOTAL_W-1:0]   o_char_total;

    // Characters still owed by the block, oldest first.
    t_char pending_chars[$];
    int    mismatches;
    bit    full_rate;

    uint_to_decimal_ascii #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_fixed_digits (i_fixed_digits),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_char_code    (o_char_code),
        .o_last_char    (o_last_char),
        .o_char_total   (o_char_total)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

    // Work out the decimal characters of one value and queue them.
    task automatic predict_chars(input logic [u2da_pkg::VALUE_W-1:0] value,
                                 input logic [u2da_pkg::FIXED_W-1:0] req);
        logic [u2da_pkg::BCD_W-1:0]   digits [MAX_DIGITS];
        logic [u2da_pkg::VALUE_W-1:0] rest;
        int unsigned                  count;
        int unsigned                  pos;
        t_char                        entry;
        rest = value;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            digits[i] = u2da_pkg::BCD_W'(rest % RADIX);
            rest      = rest / RADIX;
        end
        if (req == '0) begin
            // Minimal mode: as many digits as the value needs, one for zero.
            count = 0;
            rest  = value;
            while (rest > 0) begin
                rest  = rest / RADIX;
                count = count + 1;
            end
            if (count == 0) count = 1;
            if (count > MAX_DIGITS) count = MAX_DIGITS;
        end else begin
            // Fixed mode saturates at the widest field.
            count = (req > MAX_DIGITS) ? MAX_DIGITS : req;
        end
        for (int unsigned i = 0; i < count; i++) begin
            pos         = count - 1 - i;
            entry.code  = u2da_pkg::ASCII_ZERO + u2da_pkg::CODE_W'(digits[pos]);
            entry.last  = (i + 1 == count);
            entry.total = u2da_pkg::TOTAL_W'(count);
            pending_chars.push_back(entry);
        end
    endtask

    // Offer one value and hold it until the transfer happens.
    task automatic send_value(input logic [u2da_pkg::VALUE_W-1:0] value,
                              input logic [u2da_pkg::FIXED_W-1:0] req);
        int gap;
        gap = full_rate ? 0 : $urandom_range(MAX_IDLE, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_chars(value, req);
        i_valid        <= 1'b1;
        i_value        <= value;
        i_fixed_digits <= req;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // A value with a random number of decimal digits, or fully random bits.
    function automatic logic [u2da_pkg::VALUE_W-1:0] rand_value();
        int unsigned len;
        longint      lo;
        longint      hi;
        if ($urandom_range(3, 0) == 0) return $urandom;
        len = $urandom_range(u2da_pkg::NUM_BCD, 1);
        lo  = (len == 1) ? 0 : 10 ** (len - 1);
        hi  = (len == u2da_pkg::NUM_BCD) ? 64'hFFFF_FFFF : 10 ** len - 1;
        return $urandom_range(u2da_pkg::VALUE_W'(hi), u2da_pkg::VALUE_W'(lo));
    endfunction

    // Mostly legal digit counts, sometimes counts that must saturate.
    function automatic logic [u2da_pkg::FIXED_W-1:0] rand_req();
        case ($urandom_range(7, 0))
            0, 1, 2: return '0;
            3:       return u2da_pkg::FIXED_W'($urandom_range(31, MAX_DIGITS + 1));
            default: return u2da_pkg::FIXED_W'($urandom_range(MAX_DIGITS, 1));
        endcase
    endfunction

    // Minimal mode at the extremes and around digit-count boundaries.
    task automatic test_minimal_mode();
        send_value(32'd0, 5'd0);
        send_value(32'd9, 5'd0);
        send_value(32'd10, 5'd0);
        send_value(32'd999_999_999, 5'd0);
        send_value(32'd1_000_000_000, 5'd0);
        send_value(32'hFFFF_FFFF, 5'd0);
        send_value(32'h8000_0000, 5'd0);
        send_value(32'h5555_5555, 5'd0);
    endtask

    // Fixed mode: padding, dropped high digits and saturation.
    task automatic test_fixed_mode();
        send_value(32'd0, 5'd1);
        send_value(32'd0, 5'd16);
        send_value(32'hFFFF_FFFF, 5'd1);
        send_value(32'hFFFF_FFFF, 5'd10);
        send_value(32'hFFFF_FFFF, 5'd16);
        send_value(32'hFFFF_FFFF, 5'd17);
        send_value(32'hFFFF_FFFF, 5'd31);
        send_value(32'd12345, 5'd3);
        send_value(32'd5, 5'd10);
        send_value(32'hAAAA_AAAA, 5'd11);
        send_value(32'd4_000_000_001, 5'd9);
    endtask

    // Random values and digit counts with random idling on both sides.
    task automatic test_random_mix();
        full_rate = 1'b0;
        repeat (RANDOM_ITEMS) send_value(rand_value(), rand_req());
    endtask

    // A stretch with neither side idling.
    task automatic test_back_to_back();
        full_rate = 1'b1;
        repeat (BURST_ITEMS) send_value(rand_value(), rand_req());
        full_rate = 1'b0;
    endtask

    // Output side: random stalls, then check each transferred character.
    initial begin : char_sink
        int    stall;
        t_char got;
        t_char want;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = full_rate ? 0 : $urandom_range(MAX_IDLE, 0);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.code  = o_char_code;
            got.last  = o_last_char;
            got.total = o_char_total;
            if (pending_chars.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("Unexpected character: code %0d last %0b total %0d",
                             got.code, got.last, got.total);
                mismatches++;
            end else begin
                want = pending_chars.pop_front();
                if (got.code !== want.code || got.last !== want.last ||
                        got.total !== want.total) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("Mismatch: expected code %0d last %0b total %0d, got code %0d last %0b total %0d",
                                 want.code, want.last, want.total,
                                 got.code, got.last, got.total);
                    mismatches++;
                end
            end
        end
    end

    // Reset, run the tests in turn, drain and report.
    initial begin
        mismatches      = 0;
        full_rate       = 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_value        <= '0;
        i_fixed_digits <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_minimal_mode();
        test_fixed_mode();
        test_random_mix();
        test_back_to_back();
        i_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/u2da_pkg.sv
src/u2da_bcd_cell.sv
src/u2da_bcd_chain.sv
src/uint_to_decimal_ascii.sv
tb/tb_uint_to_decimal_ascii.sv
